FILE: rtl/tba_pkg.sv
// Shared types and constants for the temperature boxcar average block.
// No dependencies; every other file depends on this package.
package tba_pkg;

   localparam int SAMPLE_W = 18;
   localparam int LIMIT_W  = 17;
   localparam int CELSIUS_W = 17;
   localparam int F_W      = 19;

   // floor(9*c/5) == (c * C_TO_F_MUL) >> C_TO_F_SHIFT for every c below 2**17
   localparam int C_TO_F_SHIFT = 24;
   localparam int C_TO_F_MUL_W = 25;
   localparam logic [C_TO_F_MUL_W-1:0] C_TO_F_MUL = 25'd30198996;
   localparam logic [F_W-1:0] F_OFFSET = 19'd32000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd85000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [LIMIT_W-1:0]         limit_type;
   typedef logic [CELSIUS_W-1:0]       celsius_type;
   typedef logic [F_W-1:0]             temp_f_type;
   typedef logic [QCNT_W-1:0]          qcount_type;

   typedef struct packed {
      logic       valid;
      temp_f_type data;
   } q_item_type;

endpackage

FILE: rtl/tba_channels.sv
// Valid/ready channel interfaces for request and response items.
// Depends on tba_pkg for the payload types.
interface tba_req_if;
   logic               valid;
   logic               ready;
   tba_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface tba_rsp_if;
   logic                valid;
   logic                ready;
   tba_pkg::temp_f_type avg_milli_f;

   modport source (output valid, output avg_milli_f, input ready);
   modport sink   (input valid, input avg_milli_f, output ready);
endinterface

FILE: rtl/tba_queue.sv
// Short FIFO of converted readings between the front and the window logic.
// Depends on tba_pkg.
module tba_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  tba_pkg::q_item_type    push,
   input  logic                   pop,
   output tba_pkg::q_item_type    head,
   output tba_pkg::qcount_type    count
);
   import tba_pkg::*;

   temp_f_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   qcount_type        count_ff, count_in;
   logic              do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.data;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.data  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

FILE: rtl/tba_front.sv
// Front end: limit register, reading classification and Celsius to Fahrenheit
// conversion. Depends on tba_pkg; feeds tba_queue.
module tba_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  tba_pkg::limit_type    csr_wdata,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tba_pkg::sample_type   in_sample,
   input  tba_pkg::qcount_type   q_count,
   output tba_pkg::q_item_type   push
);
   import tba_pkg::*;

   localparam int PROD_W = CELSIUS_W + C_TO_F_MUL_W;

   limit_type   limit_ff;
   logic        v1_ff, v1_in;
   celsius_type c1_ff;
   logic        v2_ff;
   temp_f_type  f2_ff, f2_in;
   logic [PROD_W-1:0] prod;
   logic [QCNT_W:0]   committed;
   logic        in_range;

   // credit check: queued entries plus those still in conversion
   assign committed = {1'b0, q_count} + (QCNT_W+1)'(v1_ff) + (QCNT_W+1)'(v2_ff);
   assign in_ready  = committed < (QCNT_W+1)'(QUEUE_DEPTH);

   // above zero and below the limit
   assign in_range = !in_sample[SAMPLE_W-1] && (in_sample != '0)
                     && (in_sample[CELSIUS_W-1:0] < limit_ff);
   assign v1_in = in_valid && in_ready && in_range;

   assign prod  = PROD_W'(c1_ff) * PROD_W'(C_TO_F_MUL);
   assign f2_in = F_W'(prod[PROD_W-1:C_TO_F_SHIFT]) + F_OFFSET;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff <= in_sample[CELSIUS_W-1:0];
      f2_ff <= f2_in;
   end

   assign push.valid = v2_ff;
   assign push.data  = f2_ff;

endmodule

FILE: rtl/tba_window.sv
// Window store and running sum: read-modify-write of one slot per reading.
// Depends on tba_pkg; pops tba_queue and feeds tba_average.
module tba_window #(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  tba_pkg::q_item_type head,
   output logic                pop,
   output logic                sum_valid,
   output logic [tba_pkg::F_W+$clog2(WINDOW_DEPTH)-1:0] sum
);
   import tba_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W = F_W + IDX_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

   temp_f_type store_mem [WINDOW_DEPTH];

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             lap_ff, lap_in;
   logic             v1_ff;
   temp_f_type       f1_ff;
   logic [IDX_W-1:0] idx1_ff;
   logic             lap1_ff;
   temp_f_type       rd_ff;
   logic             primed_ff;
   temp_f_type       first_ff;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             sumv_ff;
   temp_f_type       old_f;
   logic             update;

   assign pop    = advance && head.valid;
   assign update = advance && v1_ff;

   always_comb begin
      idx_in = idx_ff;
      lap_in = lap_ff;
      if (pop) begin
         idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
         lap_in = lap_ff || (idx_ff == IDX_LAST);
      end
   end

   // until the ring has gone round once, unwritten slots count as the first reading
   assign old_f  = lap1_ff ? rd_ff : first_ff;
   assign sum_in = primed_ff ? (sum_ff - SUM_W'(old_f) + SUM_W'(f1_ff))
                             : (SUM_W'(WINDOW_DEPTH) * SUM_W'(f1_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         lap_ff    <= 1'b0;
         v1_ff     <= 1'b0;
         primed_ff <= 1'b0;
         sum_ff    <= '0;
         sumv_ff   <= 1'b0;
      end else if (advance) begin
         idx_ff  <= idx_in;
         lap_ff  <= lap_in;
         v1_ff   <= pop;
         sumv_ff <= v1_ff;
         if (v1_ff) begin
            primed_ff <= 1'b1;
            sum_ff    <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ff   <= head.data;
         idx1_ff <= idx_ff;
         lap1_ff <= lap_ff;
         rd_ff   <= store_mem[idx_ff];
      end
      if (update) begin
         store_mem[idx1_ff] <= f1_ff;
         if (!primed_ff) begin
            first_ff <= f1_ff;
         end
      end
   end

   assign sum_valid = sumv_ff;
   assign sum       = sum_ff;

endmodule

FILE: rtl/tba_average.sv
// Divides the running sum by the window depth and holds the result for output.
// Depends on tba_pkg; reciprocal multiply with one correction step.
module tba_average #(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                sum_valid,
   input  logic [tba_pkg::F_W+$clog2(WINDOW_DEPTH)-1:0] sum,
   output logic                advance,
   output logic                out_valid,
   input  logic                out_ready,
   output tba_pkg::temp_f_type out_avg
);
   import tba_pkg::*;

   localparam int SUM_W  = F_W + $clog2(WINDOW_DEPTH);
   localparam int PROD_W = 2 * SUM_W;
   localparam longint unsigned RECIP_L = (64'd1 << SUM_W) / WINDOW_DEPTH;
   localparam logic [SUM_W-1:0] RECIP = SUM_W'(RECIP_L);
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(WINDOW_DEPTH);

   logic              v1_ff, v2_ff, v3_ff, out_v_ff;
   logic [PROD_W-1:0] prod1_ff;
   logic [SUM_W-1:0]  sum1_ff, sum2_ff, sum3_ff;
   temp_f_type        q2_ff, q3_ff;
   logic [SUM_W-1:0]  qd3_ff;
   logic [SUM_W-1:0]  rem;
   temp_f_type        out_ff, out_in;

   assign advance = !out_v_ff || out_ready;

   // the estimate is exact or one short
   assign rem    = sum3_ff - qd3_ff;
   assign out_in = (rem >= DEPTH_S) ? q3_ff + 1'b1 : q3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         v1_ff    <= sum_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         out_v_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod1_ff <= PROD_W'(sum) * PROD_W'(RECIP);
         sum1_ff  <= sum;
         q2_ff    <= F_W'(prod1_ff[PROD_W-1:SUM_W]);
         sum2_ff  <= sum1_ff;
         qd3_ff   <= SUM_W'(q2_ff) * DEPTH_S;
         q3_ff    <= q2_ff;
         sum3_ff  <= sum2_ff;
         out_ff   <= out_in;
      end
   end

   assign out_valid = out_v_ff;
   assign out_avg   = out_ff;

endmodule

FILE: rtl/temperature_boxcar_average.sv
// Temperature boxcar average: top level. Depends on tba_pkg, tba_channels,
// tba_front, tba_queue, tba_window and tba_average.
//
// Takes signed milli-degree Celsius readings on req_ch and returns, for every
// reading above zero and below the upper limit (csr_wdata, written with
// csr_we while idle, reset value 85000), the average of the last WINDOW_DEPTH
// converted readings in milli-degrees Fahrenheit on rsp_ch. Rejected readings
// are consumed and give no response. The first accepted reading after reset
// fills the whole window with its own value. Throughput is one reading per
// clock while the response is not stalled: the window store does one read and
// one write per cycle, and the running sum is updated once per reading. From
// request to response a reading passes classification and conversion, the
// queue, the window read-modify-write and the division by the depth. The
// window store needs no clearing pass after reset; slots not yet revisited
// since the first reading read back as that reading. A stalled response
// holds the back end; the queue and request credit then hold the front end.
module temperature_boxcar_average #(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  tba_pkg::limit_type  csr_wdata,
   tba_req_if.sink             req_ch,
   tba_rsp_if.source           rsp_ch
);
   import tba_pkg::*;

   localparam int SUM_W = F_W + $clog2(WINDOW_DEPTH);

   q_item_type       push;
   q_item_type       head;
   qcount_type       q_count;
   logic             pop;
   logic             advance;
   logic             sum_valid;
   logic [SUM_W-1:0] sum;

   // classify and convert; drop out-of-range readings here
   tba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_sample (req_ch.sample),
      .q_count   (q_count),
      .push      (push)
   );

   // decouple front from back
   tba_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   // replace the oldest slot and advance the running sum
   tba_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .head      (head),
      .pop       (pop),
      .sum_valid (sum_valid),
      .sum       (sum)
   );

   // divide by depth and hold the response
   tba_average #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_average (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid),
      .sum       (sum),
      .advance   (advance),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_avg   (rsp_ch.avg_milli_f)
   );

endmodule

FILE: tb/sv/temperature_boxcar_average_tb.sv
// Self-checking testbench for temperature_boxcar_average: a directed table, then random
// readings under three idle patterns, checked against typed-in values or a built-in window-average predictor.
// Depends on rtl/tba_pkg.sv, rtl/tba_channels.sv and the block's RTL.
module temperature_boxcar_average_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tba_pkg::*;

   localparam int WINDOW       = 256;
   localparam int SUM_W        = F_W + $clog2(WINDOW);
   localparam int RESET_CYCLES = 12;
   // Enough cycles for a request to come out the far end, with margin.
   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 500;
   localparam limit_type LIMIT_MAX = '1;

   typedef enum logic {ROW_SAMPLE, ROW_LIMIT} row_kind_type;
   // How a table row sets its expectation: from the predictor, no result, or typed in.
   typedef enum logic [1:0] {OUT_PREDICT, OUT_NONE, OUT_VALUE} outcome_type;

   typedef struct {
      row_kind_type kind;
      int           value;
      outcome_type  outcome;
      temp_f_type   avg;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 21;

   // Directed requests and limit writes. Rejections, the priming reading and the reading after it
   // are typed in; the rest of what depends on the window contents is left to the predictor.
   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{ROW_SAMPLE,       0, OUT_NONE,    '0},       // zero is not above zero
      '{ROW_SAMPLE,      -1, OUT_NONE,    '0},
      '{ROW_SAMPLE, -131072, OUT_NONE,    '0},       // most negative reading
      '{ROW_SAMPLE,   85000, OUT_NONE,    '0},       // exactly at the reset limit
      '{ROW_SAMPLE,       1, OUT_VALUE,   19'd32001}, // primes the whole window
      '{ROW_SAMPLE,       1, OUT_VALUE,   19'd32001},
      '{ROW_SAMPLE,   84999, OUT_PREDICT, '0},       // just under the reset limit
      '{ROW_SAMPLE,  131071, OUT_NONE,    '0},       // largest positive, above limit
      '{ROW_LIMIT,   131071, OUT_NONE,    '0},       // widest limit
      '{ROW_SAMPLE,  131071, OUT_NONE,    '0},       // at the widest limit
      '{ROW_SAMPLE,  131070, OUT_PREDICT, '0},       // largest accepted reading
      '{ROW_LIMIT,        0, OUT_NONE,    '0},       // zero limit rejects everything
      '{ROW_SAMPLE,       1, OUT_NONE,    '0},
      '{ROW_SAMPLE,   65536, OUT_NONE,    '0},
      '{ROW_LIMIT,        1, OUT_NONE,    '0},       // smallest nonzero limit
      '{ROW_SAMPLE,       1, OUT_NONE,    '0},
      '{ROW_SAMPLE,  -65536, OUT_NONE,    '0},
      '{ROW_LIMIT,    85000, OUT_NONE,    '0},       // back to the reset value
      '{ROW_SAMPLE,       5, OUT_PREDICT, '0},
      '{ROW_SAMPLE,       2, OUT_PREDICT, '0},
      '{ROW_SAMPLE,   84999, OUT_PREDICT, '0}
   };

   logic      clock = 1'b0;
   logic      reset;
   logic      csr_we;
   limit_type csr_wdata;

   tba_req_if req_ch ();
   tba_rsp_if rsp_ch ();

   temperature_boxcar_average #(
      .WINDOW_DEPTH(WINDOW)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

   // Predictor state: limit register, priming flag, window slots and running sum.
   limit_type                   limit_reg;
   bit                          window_primed;
   logic [$clog2(WINDOW)-1:0]   slot_index;
   temp_f_type                  window_slots [WINDOW];
   logic [SUM_W-1:0]            window_sum;

   temp_f_type pending_averages [$];
   temp_f_type expected_avg;

   int send_idle_pct = 9;
   int recv_idle_pct = 81;
   int error_count;
   int requests_sent;
   int readings_accepted;
   int averages_checked;
   int limit_writes;
   int idle_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Work out the window average that a reading produces, if it is accepted at all.
   function automatic bit predict_average(input sample_type reading, output temp_f_type avg);
      int         celsius;
      temp_f_type fahrenheit;
      celsius = int'(reading);
      avg = '0;
      if (celsius <= 0 || celsius >= int'(limit_reg))
         return 1'b0;
      fahrenheit = temp_f_type'((celsius * 9) / 5 + 32000);
      if (!window_primed) begin
         foreach (window_slots[i])
            window_slots[i] = fahrenheit;
         window_sum    = SUM_W'(WINDOW * int'(fahrenheit));
         window_primed = 1'b1;
      end
      window_sum = window_sum - window_slots[slot_index] + fahrenheit;
      window_slots[slot_index] = fahrenheit;
      slot_index++;
      readings_accepted++;
      avg = temp_f_type'(window_sum / WINDOW);
      return 1'b1;
   endfunction

   // Draw a reading: mostly inside the accepted band, the rest rejections and raw noise.
   function automatic sample_type random_reading();
      int pick;
      pick = $urandom_range(99);
      if (pick < 78 && limit_reg > 1)
         return sample_type'($urandom_range(int'(limit_reg) - 1, 1));
      else if (pick < 82 && limit_reg > 1)
         return sample_type'($urandom_range(int'(limit_reg) - 1,
                                            (int'(limit_reg) > 64) ? int'(limit_reg) - 64 : 1));
      else if (pick < 88)
         return sample_type'(-$urandom_range(131072, 0));
      else if (pick < 93)
         return sample_type'($urandom_range(131071, int'(limit_reg)));
      return sample_type'($urandom);
   endfunction

   // Call at a falling edge; returns at a falling edge with the request still presented.
   task automatic send_request(input sample_type reading, input outcome_type outcome,
                               input temp_f_type typed_avg);
      temp_f_type predicted;
      bit         has_result;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= reading;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      requests_sent++;
      has_result = predict_average(reading, predicted);
      case (outcome)
         OUT_PREDICT: if (has_result) pending_averages.push_back(predicted);
         OUT_VALUE:   pending_averages.push_back(typed_avg);
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Drop valid, hold until every expected average is back, then let the pipe empty.
   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      while (pending_averages.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Call at a falling edge with the block idle.
   task automatic write_limit(input limit_type value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      limit_reg = value;
      limit_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Receiver: stall at random with the current percentage.
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

   // Compare every accepted average with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_averages.size() == 0) begin
            $display("%0t: unexpected average, expected none, got %0d",
                     $time, rsp_ch.avg_milli_f);
            error_count++;
         end else begin
            expected_avg = pending_averages.pop_front();
            if (rsp_ch.avg_milli_f !== expected_avg) begin
               $display("%0t: avg_milli_f mismatch, expected %0d, got %0d",
                        $time, expected_avg, rsp_ch.avg_milli_f);
               error_count++;
            end
         end
         averages_checked++;
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d averages outstanding",
                  $time, STALL_LIMIT, pending_averages.size());
         $display("temperature_boxcar_average_tb NOT OK");
         $finish;
      end
   end

   initial begin
      limit_type phase_limit;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = LIMIT_RESET;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      rsp_ch.ready  = 1'b0;
      limit_reg     = LIMIT_RESET;
      window_primed = 1'b0;
      slot_index    = '0;
      window_sum    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table; limit writes only go in once the block is idle.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_LIMIT) begin
            wait_until_drained();
            write_limit(limit_type'(directed_rows[r].value));
         end else begin
            send_request(sample_type'(directed_rows[r].value), directed_rows[r].outcome,
                         directed_rows[r].avg);
         end
      end

      // Random phases: sender mostly busy, then receiver mostly busy, then no idling.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 9;  recv_idle_pct = 81; phase_limit = LIMIT_MAX; end
            1: begin
               send_idle_pct = 81; recv_idle_pct = 9;
               phase_limit = limit_type'($urandom_range(131071, 1000));
            end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; phase_limit = LIMIT_RESET; end
         endcase
         wait_until_drained();
         write_limit(phase_limit);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Hold requests mid-phase until the pipe has emptied completely.
            if (phase == 1 && n == PHASE_ITEMS / 2)
               wait_until_drained();
            send_request(random_reading(), OUT_PREDICT, '0);
         end
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d accepted readings, %0d window wraps), %0d averages,",
               requests_sent, readings_accepted, readings_accepted / WINDOW, averages_checked);
      $display("%0d limit writes across three handshake idle patterns; %0d mismatches.",
               limit_writes, error_count);
      if (error_count == 0 && pending_averages.size() == 0)
         $display("temperature_boxcar_average_tb OK");
      else
         $display("temperature_boxcar_average_tb NOT OK");
      $finish;
   end

endmodule
